>>> rtl/mwo_pkg.sv
// Shared constants, codes and the command type of the multiframe wavetable oscillator.
// No dependencies; every other file of the block imports this package.
package mwo_pkg;

  // Table geometry
  localparam int unsigned TABLE_SIZE  = 2048;
  localparam int unsigned MAX_FRAMES  = 256;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
  localparam int unsigned FRAME_SLOTS = TABLE_SIZE + 1;
  localparam int unsigned STORE_DEPTH = MAX_FRAMES * FRAME_SLOTS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned FRAME_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned FCNT_W      = $clog2(MAX_FRAMES + 1);

  // Phase accumulator: integer table index above the fraction
  localparam int unsigned PHASE_W = IDX_W + FRAC_W;

  // Field and register widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned INC_W     = 27;
  localparam int unsigned STATE_W   = 8;
  localparam int unsigned STATE_MAX = (1 << STATE_W) - 1;
  localparam int unsigned STATE_HALF = STATE_MAX / 2;
  localparam int unsigned PROD_W    = STATE_W + FRAME_W;

  // Interpolation datapath
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned MUL_W  = DIFF_W + FRAC_W + 1;

  // Queues
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned OPTR_W      = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W      = $clog2(OUT_DEPTH + 1);

  // Configuration port
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_SHIFT = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RENDER  = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [0:0] {
    REG_PHASE_INC   = 1'b0,
    REG_TABLE_STATE = 1'b1
  } reg_index_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_RENDER = 1'b1
  } op_kind_e;

  // One command from the front end to the table engine
  typedef struct packed {
    op_kind_e             kind;
    logic [ADDR_W-1:0]    addr;       // write address
    logic [SAMPLE_W-1:0]  data;       // write data
    logic                 guard;      // also write guard entry at addr+1
    logic [SAMPLE_W-1:0]  guard_data;
    logic [FRAME_W-1:0]   fcm1;       // complete frames minus one
    logic                 empty;      // no complete frame
    logic [IDX_W-1:0]     idx;
    logic [FRAC_W-1:0]    frac;
  } op_t;

endpackage

>>> rtl/mwo_if.sv
// Valid/ready channel interfaces for the input items and the output samples.
// Depends on mwo_pkg for the field widths.
interface mwo_in_if import mwo_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [ACTION_W-1:0]         action;
  logic signed [SAMPLE_W-1:0]  sample_in;

  modport source (output valid, output action, output sample_in, input ready);
  modport sink   (input valid, input action, input sample_in, output ready);
endinterface

interface mwo_out_if import mwo_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

>>> rtl/mwo_front.sv
// Front end: accepts input beats, tracks load position, frame count and phase,
// and turns load and render beats into writes or render commands. Uses mwo_pkg, mwo_if.
module mwo_front import mwo_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mwo_in_if.sink            in_i,
  input  logic [INC_W-1:0]  phase_inc_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output op_t               push_op_o
);

  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [IDX_W-1:0]    load_pos_q, load_pos_d;
  logic [FCNT_W-1:0]   frames_q, frames_d;
  logic [SAMPLE_W-1:0] first_q, first_d;
  logic                accept;
  logic                room;
  logic                last_slot;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;
  assign room       = frames_q < FCNT_W'(MAX_FRAMES);
  assign last_slot  = load_pos_q == IDX_W'(TABLE_SIZE - 1);

  // Classify the beat and build its command
  always_comb begin
    push_valid_o         = 1'b0;
    push_op_o            = '0;
    push_op_o.kind       = OP_WRITE;
    push_op_o.addr       = ADDR_W'(frames_q) * ADDR_W'(FRAME_SLOTS) + ADDR_W'(load_pos_q);
    push_op_o.data       = in_i.sample_in;
    push_op_o.guard      = last_slot;
    push_op_o.guard_data = first_q;
    push_op_o.fcm1       = FRAME_W'(frames_q - FCNT_W'(1));
    push_op_o.empty      = frames_q == '0;
    push_op_o.idx        = phase_q[PHASE_W-1:FRAC_W];
    push_op_o.frac       = phase_q[FRAC_W-1:0];
    phase_d              = phase_q;
    load_pos_d           = load_pos_q;
    frames_d             = frames_q;
    first_d              = first_q;
    case (in_i.action)
      ACT_LOAD: begin
        if (room) begin
          push_valid_o = in_i.valid;
          if (load_pos_q == '0) begin
            first_d = in_i.sample_in;
          end
          if (last_slot) begin
            load_pos_d = '0;
            frames_d   = frames_q + FCNT_W'(1);
          end else begin
            load_pos_d = load_pos_q + IDX_W'(1);
          end
        end
      end
      ACT_RENDER: begin
        push_valid_o   = in_i.valid;
        push_op_o.kind = OP_RENDER;
        // Range is a power of two: wrap by truncation
        phase_d        = phase_q + PHASE_W'(phase_inc_i);
      end
      ACT_RESTART: begin
        load_pos_d = '0;
        frames_d   = '0;
      end
      default: begin
        // Unused code: drop the beat
      end
    endcase
  end

  // Advance state on accepted beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      load_pos_q <= '0;
      frames_q   <= '0;
      first_q    <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      load_pos_q <= load_pos_d;
      frames_q   <= frames_d;
      first_q    <= first_d;
    end
  end

endmodule

>>> rtl/mwo_queue.sv
// Short command queue between the front end and the table engine.
// Uses op_t and depth constants from mwo_pkg.
module mwo_queue import mwo_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  op_t               entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Hold command payloads
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

>>> rtl/mwo_back.sv
// Table engine: frame select, single-port table memory, interpolation and
// output buffer. Uses mwo_pkg and mwo_if.
module mwo_back import mwo_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  op_t                 pop_op_i,
  input  logic [STATE_W-1:0]  table_state_i,
  mwo_out_if.source           out_o
);

  // Stage 1: knob times (frame count minus one)
  logic              s1_v_q;
  op_t               s1_op_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic              s1_ready;

  // Stage 2: frame number and table address
  logic              s2_v_q;
  op_t               s2_op_q;
  logic [ADDR_W-1:0] s2_addr_q;
  logic              s2_ready;
  logic [PROD_W:0]   frame_sum;
  logic [FRAME_W-1:0] frame;
  logic [ADDR_W-1:0] s1_addr;

  // Stage 3: memory access, one or two steps
  logic              s3_v_q;
  op_t               s3_op_q;
  logic [ADDR_W-1:0] s3_addr_q;
  logic              sub_q;
  logic              s3_ready, s3_step, s3_last, is_rd, two_step, credit_ok, rd_start;
  logic [ADDR_W-1:0] mem_addr;
  logic [SAMPLE_W-1:0] mem_wdata;

  logic [SAMPLE_W-1:0] store_q [STORE_DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Read tags
  logic              rd0_v_q, rd1_v_q;
  logic [FRAC_W-1:0] tag_frac_q;
  logic              tag_empty_q;
  logic [SAMPLE_W-1:0] s0_q;

  // Multiply stage
  logic                     mul_v_q;
  logic signed [MUL_W-1:0]  mul_q;
  logic [SAMPLE_W-1:0]      mul_s0_q;
  logic                     mul_empty_q;
  logic signed [DIFF_W-1:0] diff;
  logic signed [FRAC_W:0]   frac_s;
  logic signed [MUL_W-1:0]  round_sum;
  logic [SAMPLE_W-1:0]      result;

  // Output buffer
  logic [SAMPLE_W-1:0] ofifo_q [OUT_DEPTH];
  logic [OPTR_W-1:0]   owr_q, ord_q;
  logic [OCNT_W-1:0]   ocnt_q;
  logic [OCNT_W-1:0]   pending_q;
  logic                out_pop;

  // Handshake through the stages
  assign s1_ready    = !s1_v_q || s2_ready;
  assign s2_ready    = !s2_v_q || s3_ready;
  assign pop_ready_o = s1_ready;

  assign is_rd     = s3_op_q.kind == OP_RENDER;
  assign two_step  = is_rd || s3_op_q.guard;
  assign credit_ok = pending_q < OCNT_W'(OUT_DEPTH);
  assign s3_step   = s3_v_q && !(is_rd && !sub_q && !credit_ok);
  assign s3_last   = s3_step && (!two_step || sub_q);
  assign s3_ready  = !s3_v_q || s3_last;
  assign rd_start  = s3_step && is_rd && !sub_q;

  // Round the frame number half up: (y + y/256 + 1)/256 equals y/255 here
  always_comb begin
    frame_sum = (PROD_W+1)'(s1_prod_q) + (PROD_W+1)'(s1_prod_q >> STATE_W) + (PROD_W+1)'(1);
    frame     = FRAME_W'(frame_sum >> STATE_W);
    if (s1_op_q.kind == OP_RENDER) begin
      s1_addr = ADDR_W'(frame) * ADDR_W'(FRAME_SLOTS) + ADDR_W'(s1_op_q.idx);
    end else begin
      s1_addr = s1_op_q.addr;
    end
  end

  assign mem_addr  = s3_addr_q + ADDR_W'(sub_q);
  assign mem_wdata = sub_q ? s3_op_q.guard_data : s3_op_q.data;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      sub_q  <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= pop_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
      if (s3_step) begin
        sub_q <= two_step && !sub_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_ready && pop_valid_i) begin
      s1_op_q   <= pop_op_i;
      s1_prod_q <= PROD_W'(table_state_i) * PROD_W'(pop_op_i.fcm1) + PROD_W'(STATE_HALF);
    end
    if (s2_ready && s1_v_q) begin
      s2_op_q   <= s1_op_q;
      s2_addr_q <= s1_addr;
    end
    if (s3_ready && s2_v_q) begin
      s3_op_q   <= s2_op_q;
      s3_addr_q <= s2_addr_q;
    end
  end

  // Table memory, one port
  always_ff @(posedge clk_i) begin
    if (s3_step) begin
      if (!is_rd) begin
        store_q[mem_addr] <= mem_wdata;
      end else begin
        rdata_q <= store_q[mem_addr];
      end
    end
  end

  // Track the two reads of a render
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd0_v_q <= 1'b0;
      rd1_v_q <= 1'b0;
      mul_v_q <= 1'b0;
    end else begin
      rd0_v_q <= rd_start;
      rd1_v_q <= s3_step && is_rd && sub_q;
      mul_v_q <= rd1_v_q;
    end
  end

  assign diff   = $signed({rdata_q[SAMPLE_W-1], rdata_q}) - $signed({s0_q[SAMPLE_W-1], s0_q});
  assign frac_s = $signed({1'b0, tag_frac_q});

  // Capture left entry, then form the weighted difference
  always_ff @(posedge clk_i) begin
    if (s3_step && is_rd && sub_q) begin
      tag_frac_q  <= s3_op_q.frac;
      tag_empty_q <= s3_op_q.empty;
    end
    if (rd0_v_q) begin
      s0_q <= rdata_q;
    end
    if (rd1_v_q) begin
      mul_q       <= MUL_W'(diff) * MUL_W'(frac_s);
      mul_s0_q    <= s0_q;
      mul_empty_q <= tag_empty_q;
    end
  end

  // Round half up and add the left entry
  always_comb begin
    round_sum = (mul_q + (MUL_W'(1) << (FRAC_W - 1))) >>> FRAC_W;
    result    = mul_empty_q ? '0 : mul_s0_q + round_sum[SAMPLE_W-1:0];
  end

  // Output buffer
  assign out_o.valid      = ocnt_q != '0;
  assign out_o.sample_out = ofifo_q[ord_q];
  assign out_pop          = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (mul_v_q) begin
      ofifo_q[owr_q] <= result;
    end
  end

  // Count buffered results and renders still in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q     <= '0;
      ord_q     <= '0;
      ocnt_q    <= '0;
      pending_q <= '0;
    end else begin
      if (mul_v_q) begin
        owr_q <= (owr_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : owr_q + OPTR_W'(1);
      end
      if (out_pop) begin
        ord_q <= (ord_q == OPTR_W'(OUT_DEPTH - 1)) ? '0 : ord_q + OPTR_W'(1);
      end
      ocnt_q    <= ocnt_q + OCNT_W'(mul_v_q) - OCNT_W'(out_pop);
      pending_q <= pending_q + OCNT_W'(rd_start) - OCNT_W'(out_pop);
    end
  end

endmodule

>>> rtl/multiframe_wavetable_oscillator.sv
// Multiframe wavetable oscillator: input channel (load / render / restart),
// output channel of Q1.15 samples, two configuration registers on an APB port.
// Load and restart beats give no result; each render beat gives one sample.
// The input takes one beat per cycle while the command queue has room. The
// table engine writes a load in one step, a load that closes a frame (guard
// entry) in two, and reads a render in two, since the two adjacent entries
// come from one single-port table memory.
// Reset clears the phase, the load position, the frame count and both
// registers; the table memory is not cleared and needs no startup pass.
// A stalled receiver fills a 4-entry output buffer; renders then hold in the
// engine, the command queue fills and input ready drops. Nothing is lost.
// Registers: 0x0 phase increment (27 bits, 16 fraction bits), 0x4 frame knob.
// Write registers only while the block is idle.
// Uses mwo_pkg, mwo_if, mwo_front, mwo_queue and mwo_back.
module multiframe_wavetable_oscillator import mwo_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  mwo_in_if.sink             in_i,
  mwo_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  logic [INC_W-1:0]   phase_inc_q;
  logic [STATE_W-1:0] table_state_q;
  logic               cfg_we;
  reg_index_e         reg_sel;

  logic push_valid, push_ready, pop_valid, pop_ready;
  op_t  push_op, pop_op;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_e'(paddr[PADDR_W-1:REG_SHIFT]);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_inc_q   <= '0;
      table_state_q <= '0;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_PHASE_INC:   phase_inc_q   <= pwdata[INC_W-1:0];
        REG_TABLE_STATE: table_state_q <= pwdata[STATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      REG_PHASE_INC:   prdata = APB_DW'(phase_inc_q);
      REG_TABLE_STATE: prdata = APB_DW'(table_state_q);
      default:         prdata = '0;
    endcase
  end

  mwo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .phase_inc_i  (phase_inc_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_op_o    (push_op)
  );

  mwo_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_op_i    (push_op),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_op_o     (pop_op)
  );

  mwo_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_op_i      (pop_op),
    .table_state_i (table_state_q),
    .out_o         (out_o)
  );

endmodule

>>> tb/multiframe_wavetable_oscillator_test.sv
// Self-checking bench for multiframe_wavetable_oscillator: loads a frame, renders samples
// under bursty input and a stalling output, and compares every sample with a local model.
// Depends on mwo_pkg and the mwo_in_if / mwo_out_if channel interfaces.
module multiframe_wavetable_oscillator_test;
  import mwo_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE   = 2'd3;
  localparam logic [SAMPLE_W-1:0] SIGN_BIT    = SAMPLE_W'(1) << (SAMPLE_W - 1);
  localparam int unsigned         INC_MAX     = (1 << INC_W) - 1;
  localparam int unsigned         FRAC_MASK   = (1 << FRAC_W) - 1;
  localparam int unsigned         SETTLE_WAIT = 16;
  localparam int unsigned         STALL_LIMIT = 2000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SAMPLE_W-1:0] sample;
  } osc_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mwo_in_if  in_bus ();
  mwo_out_if out_bus ();

  multiframe_wavetable_oscillator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Beats waiting for the driver and samples waiting for the output
  osc_beat_t           pending_beats[$];
  logic [SAMPLE_W-1:0] expected_samples[$];
  int unsigned         error_count = 0;

  // Local copy of the oscillator state and its registers
  bit   [SAMPLE_W-1:0] frame_mem [STORE_DEPTH];
  logic [PHASE_W-1:0]  phase_acc    = '0;
  int unsigned         load_pos     = 0;
  int unsigned         frames_done  = 0;
  logic [SAMPLE_W-1:0] first_sample = '0;
  logic [INC_W-1:0]    step_size    = '0;
  logic [STATE_W-1:0]  knob         = '0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Apply one accepted input beat; a render pushes the sample it must produce
  function automatic void oscillator_step(input logic [ACTION_W-1:0] act,
                                          input logic [SAMPLE_W-1:0] smp);
    int unsigned         base;
    int unsigned         frame;
    int unsigned         idx;
    longint unsigned     lo;
    longint unsigned     hi;
    longint unsigned     frac;
    longint unsigned     acc;
    logic [SAMPLE_W-1:0] result;
    case (act)
      ACT_LOAD: begin
        // drop loads once every frame slot is taken
        if (frames_done < MAX_FRAMES) begin
          base = frames_done * FRAME_SLOTS;
          if (load_pos == 0) first_sample = smp;
          frame_mem[base + load_pos] = smp;
          load_pos++;
          if (load_pos == TABLE_SIZE) begin
            frame_mem[base + TABLE_SIZE] = first_sample;
            frames_done++;
            load_pos = 0;
          end
        end
      end
      ACT_RESTART: begin
        load_pos    = 0;
        frames_done = 0;
      end
      ACT_RENDER: begin
        result = '0;
        if (frames_done != 0) begin
          // round the knob position half up across the complete frames
          frame = (2 * knob * (frames_done - 1) + STATE_MAX) / (2 * STATE_MAX);
          if (frame >= frames_done) frame = frames_done - 1;
          base = frame * FRAME_SLOTS;
          idx  = 32'(phase_acc[PHASE_W-1:FRAC_W]);
          frac = 64'(phase_acc[FRAC_W-1:0]);
          // interpolate in offset binary, round half up
          lo  = 64'(frame_mem[base + idx] ^ SIGN_BIT);
          hi  = 64'(frame_mem[base + idx + 1] ^ SIGN_BIT);
          acc = lo * ((64'd1 << FRAC_W) - frac) + hi * frac + (64'd1 << (FRAC_W - 1));
          result = acc[FRAC_W +: SAMPLE_W] ^ SIGN_BIT;
        end
        expected_samples.push_back(result);
        // table length is a power of two: the single wrap is a drop of the carry
        phase_acc = phase_acc + PHASE_W'(step_size);
      end
      default: ;
    endcase
  endfunction

  // Track register writes as the block takes them
  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready) begin
      if (paddr[REG_SHIFT] == REG_PHASE_INC) step_size <= pwdata[INC_W-1:0];
      else knob <= pwdata[STATE_W-1:0];
    end
  end

  // Predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) oscillator_step(in_bus.action, in_bus.sample_in);
  end

  // Compare every accepted output beat with the oldest prediction
  always @(posedge clk_i) begin : sample_check
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample_out expected none, got %0d", $time, out_bus.sample_out);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (want !== out_bus.sample_out) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, $signed(want),
                   out_bus.sample_out);
          error_count++;
        end
      end
    end
  end

  // Feed input beats in bursts of random length with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin : beat_driver
    osc_beat_t nxt;
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.action    <= ACT_LOAD;
      in_bus.sample_in <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        nxt = pending_beats.pop_front();
        in_bus.valid     <= 1'b1;
        in_bus.action    <= nxt.action;
        in_bus.sample_in <= nxt.sample;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                    : $urandom_range(0, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Stall the output by stepping through a 32-bit ready mask, redrawn at each wrap
  logic [31:0] ready_mask;
  logic [4:0]  mask_pos;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      ready_mask    <= '0;
      mask_pos      <= '0;
    end else begin
      out_bus.ready <= ready_mask[mask_pos];
      mask_pos      <= mask_pos + 1'b1;
      if (mask_pos == '1) begin
        case ($urandom_range(0, 3))
          0:       ready_mask <= '1;
          1:       ready_mask <= $urandom | $urandom;
          2:       ready_mask <= $urandom;
          default: ready_mask <= $urandom & $urandom & $urandom;
        endcase
      end
    end
  end

  // End the run when nothing moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("multiframe_wavetable_oscillator_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] smp);
    osc_beat_t b;
    b.action = act;
    b.sample = smp;
    pending_beats.push_back(b);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    if ($urandom_range(0, 7) != 0) return SAMPLE_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return SIGN_BIT;
      1:       return ~SIGN_BIT;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Queue one full frame of loads, with renders mixed in now and then
  task automatic queue_frame(input bit edgy, input int unsigned render_pct);
    for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
      if (edgy && (k < 16 || k >= TABLE_SIZE - 16))
        push_beat(ACT_LOAD, k[0] ? ~SIGN_BIT : SIGN_BIT);
      else
        push_beat(ACT_LOAD, rand_sample());
      if ($urandom_range(0, 99) < render_pct) push_beat(ACT_RENDER, rand_sample());
    end
  endtask

  // Mostly renders, with stray loads and spare codes as noise
  task automatic queue_mix(input int unsigned count);
    int unsigned pick;
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)      push_beat(ACT_RENDER, rand_sample());
      else if (pick < 90) push_beat(ACT_LOAD, rand_sample());
      else                push_beat(ACT_SPARE, rand_sample());
    end
  endtask

  // Hold until every beat is in and every sample is out, then let the engine drain
  task automatic settle();
    while (pending_beats.size() != 0 || in_bus.valid || expected_samples.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << REG_SHIFT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic pick_config();
    logic [INC_W-1:0]   inc;
    logic [STATE_W-1:0] pos;
    settle();
    case ($urandom_range(0, 4))
      0:       inc = INC_W'($urandom_range(0, INC_MAX));
      1:       inc = INC_W'($urandom_range(0, FRAC_MASK));
      2:       inc = INC_W'($urandom_range(0, TABLE_SIZE - 1)) << FRAC_W;
      3:       inc = INC_W'(INC_MAX - $urandom_range(0, 255));
      default: inc = INC_W'($urandom_range(1, 16));
    endcase
    if ($urandom_range(0, 3) == 0) pos = $urandom_range(0, 1) ? '1 : '0;
    else pos = STATE_W'($urandom_range(0, STATE_MAX));
    write_reg(REG_PHASE_INC, APB_DW'(inc));
    write_reg(REG_TABLE_STATE, APB_DW'(pos));
  endtask

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.action    = ACT_LOAD;
    in_bus.sample_in = '0;
    out_bus.ready    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // No complete frame: renders give zero, spare code and restart give nothing
    push_beat(ACT_RENDER, '0);
    push_beat(ACT_SPARE, ~SIGN_BIT);
    push_beat(ACT_RESTART, '0);
    for (int k = 0; k < 5; k++) push_beat(ACT_LOAD, rand_sample());
    push_beat(ACT_RENDER, '0);
    push_beat(ACT_RESTART, '0);
    push_beat(ACT_RENDER, '0);
    settle();

    // Largest step walks the phase back through the guard entry
    write_reg(REG_PHASE_INC, INC_MAX);
    write_reg(REG_TABLE_STATE, STATE_MAX);
    repeat (3) push_beat(ACT_RENDER, '0);
    queue_frame(1'b1, 1);
    repeat (8) push_beat(ACT_RENDER, '0);
    settle();
    write_reg(REG_PHASE_INC, '0);
    write_reg(REG_TABLE_STATE, '0);
    repeat (3) push_beat(ACT_RENDER, '0);

    // Random rounds over the loaded frame with a partial one behind it
    for (int unsigned r = 0; r < 5; r++) begin
      pick_config();
      queue_mix(16);
    end

    // Restart, then renders with no complete frame
    pick_config();
    push_beat(ACT_RESTART, '0);
    repeat (4) push_beat(ACT_RENDER, '0);
    queue_mix(8);

    settle();
    if (error_count == 0) $display("multiframe_wavetable_oscillator_test: clean");
    else $display("multiframe_wavetable_oscillator_test: errors");
    $finish;
  end

endmodule
